FILE: rtl/spt_pkg.sv
// spt_pkg: shared types, operation codes and saturating add for the term table
// no dependencies; used by the interfaces, the cell and the top level
package spt_pkg;

  localparam int unsigned COEF_W  = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned EXP_IO_W = 8;
  localparam int unsigned CNT_IO_W = 5;

  // operation codes of the func field
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // per-item control broadcast to every cell
  typedef struct packed {
    logic insert;  // new exponent goes in at its sorted place
    logic remove;  // matched term cancels, lower terms move up
    logic update;  // matched term takes the sum
  } cell_ctl_t;

  // signed add clamped to the 32-bit range
  function automatic logic [COEF_W-1:0] sat_add(input logic [COEF_W-1:0] a,
                                                 input logic [COEF_W-1:0] b);
    logic [COEF_W:0] s;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      sat_add = s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      sat_add = s[COEF_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/spt_if.sv
// spt_in_if / spt_out_if: valid-ready channels carrying one item each
// depends on spt_pkg for field widths
interface spt_in_if;
  logic                              valid;
  logic                              ready;
  logic [spt_pkg::FUNC_W-1:0]        func;
  logic [spt_pkg::EXP_IO_W-1:0]      term_exp;
  logic signed [spt_pkg::COEF_W-1:0] term_coef;

  modport source(output valid, output func, output term_exp, output term_coef, input ready);
  modport sink(input valid, input func, input term_exp, input term_coef, output ready);
endinterface

interface spt_out_if;
  logic                              valid;
  logic                              ready;
  logic [spt_pkg::EXP_IO_W-1:0]      degree;
  logic [spt_pkg::CNT_IO_W-1:0]      term_count;
  logic signed [spt_pkg::COEF_W-1:0] coef_read;
  logic                              dropped;

  modport source(output valid, output degree, output term_count, output coef_read,
                 output dropped, input ready);
  modport sink(input valid, input degree, input term_count, input coef_read,
               input dropped, output ready);
endinterface

FILE: rtl/spt_cell.sv
// spt_cell: one slot of the sorted term chain, exponent and coefficient
// depends on spt_pkg; shifts data with its neighbors on insert and remove
module spt_cell #(
  parameter int unsigned EXP_BITS = 8
) (
  input  logic                          clk_i,
  input  spt_pkg::cell_ctl_t            ctl_i,
  input  logic                          valid_i,
  input  logic [EXP_BITS-1:0]           key_exp_i,
  input  logic [spt_pkg::COEF_W-1:0]    key_coef_i,
  input  logic [spt_pkg::COEF_W-1:0]    sum_i,
  input  logic                          prev_gt_i,
  input  logic [EXP_BITS-1:0]           prev_exp_i,
  input  logic [spt_pkg::COEF_W-1:0]    prev_coef_i,
  input  logic [EXP_BITS-1:0]           next_exp_i,
  input  logic [spt_pkg::COEF_W-1:0]    next_coef_i,
  output logic [EXP_BITS-1:0]           exp_o,
  output logic [spt_pkg::COEF_W-1:0]    coef_o,
  output logic [EXP_BITS-1:0]           exp_next_o,
  output logic                          gt_o,
  output logic                          match_o,
  output logic [spt_pkg::COEF_W-1:0]    match_coef_o
);

  logic [EXP_BITS-1:0]        exp_q, exp_d;
  logic [spt_pkg::COEF_W-1:0] coef_q, coef_d;

  // compare against the broadcast exponent
  assign gt_o         = valid_i && (exp_q > key_exp_i);
  assign match_o      = valid_i && (exp_q == key_exp_i);
  assign match_coef_o = match_o ? coef_q : '0;

  // slot update: hold, take the new term, shift from a neighbor, or take the sum
  always_comb begin
    exp_d  = exp_q;
    coef_d = coef_q;
    if (ctl_i.insert && !gt_o) begin
      if (prev_gt_i) begin
        exp_d  = key_exp_i;
        coef_d = key_coef_i;
      end else begin
        exp_d  = prev_exp_i;
        coef_d = prev_coef_i;
      end
    end else if (ctl_i.remove && !gt_o) begin
      exp_d  = next_exp_i;
      coef_d = next_coef_i;
    end else if (ctl_i.update && match_o) begin
      coef_d = sum_i;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    coef_q <= coef_d;
  end

  assign exp_o      = exp_q;
  assign coef_o     = coef_q;
  assign exp_next_o = exp_d;

endmodule

FILE: rtl/sparse_polynomial_term_table.sv
// sparse_polynomial_term_table: top level, chain of term cells plus count and result register
// depends on spt_pkg, spt_in_if, spt_out_if and spt_cell
//
// Keeps a sparse polynomial as up to MAX_TERMS terms sorted by exponent, highest first.
// Input channel in_i carries func (add, query, clear), term_exp and term_coef; output
// channel out_o returns one item per input item: degree, term_count, coef_read, dropped.
// Every cell compares its exponent with the incoming one in parallel; an insert shifts
// lower terms one cell down, a cancelling merge shifts them one cell up, a merge adds in
// a single shared saturating adder. The whole update completes in the cycle of acceptance.
// The result is valid in the cycle after the item is accepted.
// Throughput: one item per cycle, set by the cell update at acceptance and the one-entry
// result register; in_i.ready is low only while a result waits and out_o.ready is low.
// Reset empties the table (term count zero) and drops any pending result. No clearing
// pass is needed: slots beyond the count are never read.
// A stalled receiver holds the result steady and stops further input items.
module sparse_polynomial_term_table #(
  parameter int unsigned MAX_TERMS = 16,
  parameter int unsigned EXP_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spt_in_if.sink      in_i,
  spt_out_if.source   out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);

  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       out_valid_q;
  logic [spt_pkg::EXP_IO_W-1:0] degree_q;
  logic [CNT_W-1:0]           count_q;
  logic [spt_pkg::COEF_W-1:0] coef_read_q;
  logic                       dropped_q;

  logic                       acc;
  logic [EXP_BITS-1:0]        key_exp;
  logic [spt_pkg::COEF_W-1:0] key_coef;
  logic                       is_add, is_query, is_clear;
  logic                       any_match, full, coef_zero, sum_zero, drop;
  logic [spt_pkg::COEF_W-1:0] hit_coef, sum;
  spt_pkg::cell_ctl_t         ctl;

  logic [MAX_TERMS-1:0]       valid_v, gt_v, match_v;
  logic [EXP_BITS-1:0]        exp_v      [MAX_TERMS];
  logic [EXP_BITS-1:0]        exp_next_v [MAX_TERMS];
  logic [spt_pkg::COEF_W-1:0] coef_v     [MAX_TERMS];
  logic [spt_pkg::COEF_W-1:0] mcoef_v    [MAX_TERMS];

  // handshake and decode
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign key_exp    = EXP_BITS'(in_i.term_exp);
  assign key_coef   = in_i.term_coef;
  assign is_add     = (in_i.func == spt_pkg::FUNC_ADD);
  assign is_query   = (in_i.func == spt_pkg::FUNC_QUERY);
  assign is_clear   = (in_i.func == spt_pkg::FUNC_CLEAR);

  // gather the matching coefficient, at most one cell matches
  always_comb begin
    hit_coef = '0;
    for (int i = 0; i < MAX_TERMS; i++) begin
      hit_coef = hit_coef | mcoef_v[i];
    end
  end

  assign any_match = |match_v;
  assign full      = (cnt_q == CNT_W'(MAX_TERMS));
  assign coef_zero = (key_coef == '0);
  assign sum       = spt_pkg::sat_add(hit_coef, key_coef);
  assign sum_zero  = (sum == '0);
  assign drop      = is_add && !coef_zero && !any_match && full;

  assign ctl.insert = acc && is_add && !coef_zero && !any_match && !full;
  assign ctl.remove = acc && is_add && !coef_zero && any_match && sum_zero;
  assign ctl.update = acc && is_add && !coef_zero && any_match && !sum_zero;

  // chain of cells
  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
    assign valid_v[g] = (cnt_q > CNT_W'(g));
    spt_cell #(
      .EXP_BITS(EXP_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (valid_v[g]),
      .key_exp_i   (key_exp),
      .key_coef_i  (key_coef),
      .sum_i       (sum),
      .prev_gt_i   ((g == 0) ? 1'b1 : gt_v[(g == 0) ? 0 : g-1]),
      .prev_exp_i  (exp_v[(g == 0) ? 0 : g-1]),
      .prev_coef_i (coef_v[(g == 0) ? 0 : g-1]),
      .next_exp_i  (exp_v[(g == MAX_TERMS-1) ? g : g+1]),
      .next_coef_i (coef_v[(g == MAX_TERMS-1) ? g : g+1]),
      .exp_o       (exp_v[g]),
      .coef_o      (coef_v[g]),
      .exp_next_o  (exp_next_v[g]),
      .gt_o        (gt_v[g]),
      .match_o     (match_v[g]),
      .match_coef_o(mcoef_v[g])
    );
  end

  // term count
  always_comb begin
    cnt_d = cnt_q;
    if (acc && is_clear) begin
      cnt_d = '0;
    end else if (ctl.insert) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (ctl.remove) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      degree_q    <= (cnt_d != '0) ? spt_pkg::EXP_IO_W'(exp_next_v[0]) : '0;
      count_q     <= cnt_d;
      coef_read_q <= (is_query && any_match) ? hit_coef : '0;
      dropped_q   <= drop;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.degree     = degree_q;
  assign out_o.term_count = spt_pkg::CNT_IO_W'(count_q);
  assign out_o.coef_read  = coef_read_q;
  assign out_o.dropped    = dropped_q;

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TERMS))
    else $error("term count beyond table size");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_v))
    else $error("exponent held in more than one cell");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted item produced no result");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && drop) |=> (cnt_q == CNT_W'(MAX_TERMS)) && dropped_q)
    else $error("drop reported with room in table");

endmodule

FILE: bench/tb_sparse_polynomial_term_table.sv
// tb_sparse_polynomial_term_table: self-checking bench for the sparse polynomial term table
// depends on spt_pkg, spt_in_if, spt_out_if and sparse_polynomial_term_table from rtl
// directed rows then random add/query/clear/unused-func traffic, checked against a sorted-list predictor
module tb_sparse_polynomial_term_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TERM_SLOTS = 16;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 40;
  localparam logic [spt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [spt_pkg::EXP_IO_W-1:0] degree;
    logic [spt_pkg::CNT_IO_W-1:0] term_count;
    logic [spt_pkg::COEF_W-1:0]   coef_read;
    logic                         dropped;
  } term_result_t;

  typedef struct {
    logic [spt_pkg::FUNC_W-1:0]   func;
    logic [spt_pkg::EXP_IO_W-1:0] term_exp;
    logic [spt_pkg::COEF_W-1:0]   term_coef;
    bit                           typed;
    term_result_t                 want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  spt_in_if  in_ch ();
  spt_out_if out_ch ();

  sparse_polynomial_term_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predicted polynomial: sorted exponents, highest first
  logic [spt_pkg::EXP_IO_W-1:0] poly_exp [TERM_SLOTS];
  logic [spt_pkg::COEF_W-1:0]   poly_coef[TERM_SLOTS];
  int unsigned                  poly_terms;

  term_result_t expected_results[$];
  stim_row_t    directed_rows[$];
  int unsigned  fail_count;
  int unsigned  cycle_count;
  bit           quiet_phase;
  bit           long_hold_req;

  // clock, 4 ns period
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sparse_polynomial_term_table test failed");
      $finish;
    end
  end

  function automatic logic [spt_pkg::COEF_W-1:0] clamp_coef_sum(
      logic [spt_pkg::COEF_W-1:0] a, logic [spt_pkg::COEF_W-1:0] b);
    longint sum;
    sum = longint'($signed(a)) + longint'($signed(b));
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[spt_pkg::COEF_W-1:0];
  endfunction

  // apply one item to the predicted polynomial and return its result item
  function automatic term_result_t merge_term_step(logic [spt_pkg::FUNC_W-1:0] f,
                                                   logic [spt_pkg::EXP_IO_W-1:0] e,
                                                   logic [spt_pkg::COEF_W-1:0] c);
    term_result_t r;
    int unsigned pos;
    logic [spt_pkg::COEF_W-1:0] sum;
    r = '0;
    pos = 0;
    case (f)
      spt_pkg::FUNC_ADD: begin
        if (c != '0) begin
          // first slot whose exponent is not above the new one
          while (pos < poly_terms && poly_exp[pos] > e) pos++;
          if (pos < poly_terms && poly_exp[pos] == e) begin
            sum = clamp_coef_sum(poly_coef[pos], c);
            if (sum == '0) begin
              for (int unsigned k = pos; k + 1 < poly_terms; k++) begin
                poly_exp[k]  = poly_exp[k+1];
                poly_coef[k] = poly_coef[k+1];
              end
              poly_terms--;
            end else begin
              poly_coef[pos] = sum;
            end
          end else if (poly_terms >= TERM_SLOTS) begin
            r.dropped = 1'b1;
          end else begin
            for (int unsigned k = poly_terms; k > pos; k--) begin
              poly_exp[k]  = poly_exp[k-1];
              poly_coef[k] = poly_coef[k-1];
            end
            poly_exp[pos]  = e;
            poly_coef[pos] = c;
            poly_terms++;
          end
        end
      end
      spt_pkg::FUNC_QUERY: begin
        for (int unsigned k = 0; k < poly_terms; k++) begin
          if (poly_exp[k] == e) r.coef_read = poly_coef[k];
        end
      end
      spt_pkg::FUNC_CLEAR: begin
        poly_terms = 0;
      end
      default: begin
      end
    endcase
    r.degree     = (poly_terms > 0) ? poly_exp[0] : '0;
    r.term_count = spt_pkg::CNT_IO_W'(poly_terms);
    return r;
  endfunction

  function automatic term_result_t make_result(logic [spt_pkg::EXP_IO_W-1:0] d,
                                               int unsigned n,
                                               logic [spt_pkg::COEF_W-1:0] c, logic dr);
    term_result_t r;
    r.degree     = d;
    r.term_count = spt_pkg::CNT_IO_W'(n);
    r.coef_read  = c;
    r.dropped    = dr;
    return r;
  endfunction

  function automatic void add_row(logic [spt_pkg::FUNC_W-1:0] f,
                                  logic [spt_pkg::EXP_IO_W-1:0] e,
                                  logic [spt_pkg::COEF_W-1:0] c, bit typed,
                                  term_result_t want);
    stim_row_t row;
    row.func      = f;
    row.term_exp  = e;
    row.term_coef = c;
    row.typed     = typed;
    row.want      = want;
    directed_rows = {directed_rows, row};
  endfunction

  // offer one item after a random gap, record its expected result on acceptance
  task automatic drive_item(logic [spt_pkg::FUNC_W-1:0] f, logic [spt_pkg::EXP_IO_W-1:0] e,
                            logic [spt_pkg::COEF_W-1:0] c, bit typed, term_result_t want);
    int unsigned gap;
    term_result_t pred;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.term_exp  <= e;
    in_ch.term_coef <= c;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = merge_term_step(f, e, c);
    expected_results = {expected_results, typed ? want : pred};
    @(negedge clk_i);
  endtask

  // random item biased toward exponents already held, so merges and cancels happen
  task automatic pick_random_item(output logic [spt_pkg::FUNC_W-1:0] f,
                                  output logic [spt_pkg::EXP_IO_W-1:0] e,
                                  output logic [spt_pkg::COEF_W-1:0] c);
    int unsigned roll;
    int unsigned slot;
    bit held;
    roll = $urandom_range(0, 99);
    held = (poly_terms > 0) && ($urandom_range(0, 1) == 1);
    slot = (poly_terms > 0) ? $urandom_range(0, poly_terms - 1) : 0;
    if ($urandom_range(0, 9) < 3) e = spt_pkg::EXP_IO_W'($urandom);
    else e = spt_pkg::EXP_IO_W'($urandom_range(0, 31));
    c = $urandom;
    if (roll < 60) begin
      f = spt_pkg::FUNC_ADD;
      if (held) e = poly_exp[slot];
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: if (held) c = -poly_coef[slot];
        6:                c = 32'h7fff_ffff;
        7:                c = 32'h8000_0000;
        8:                c = '0;
        9:                c = {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)};
        default: begin
        end
      endcase
    end else if (roll < 93) begin
      f = spt_pkg::FUNC_QUERY;
      if (held || $urandom_range(0, 3) != 0) begin
        if (poly_terms > 0) e = poly_exp[slot];
      end
    end else if (roll < 96) begin
      f = spt_pkg::FUNC_CLEAR;
    end else begin
      f = FUNC_UNUSED;
    end
  endtask

  // result side: random stalls, one long hold on request
  initial begin : result_sink
    int unsigned stall;
    term_result_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 3);
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      repeat (stall) begin
        out_ch.ready <= 1'b0;
        @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (expected_results.size() == 0) begin
        $error("result item with none expected: degree %0d count %0d", out_ch.degree,
               out_ch.term_count);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.degree !== want.degree) begin
          $error("degree: expected %0d, got %0d", want.degree, out_ch.degree);
          fail_count++;
        end
        if (out_ch.term_count !== want.term_count) begin
          $error("term_count: expected %0d, got %0d", want.term_count, out_ch.term_count);
          fail_count++;
        end
        if (out_ch.coef_read !== want.coef_read) begin
          $error("coef_read: expected %h, got %h", want.coef_read, out_ch.coef_read);
          fail_count++;
        end
        if (out_ch.dropped !== want.dropped) begin
          $error("dropped: expected %b, got %b", want.dropped, out_ch.dropped);
          fail_count++;
        end
      end
      @(negedge clk_i);
    end
  end

  // stimulus: reset, directed rows, random traffic, drain
  initial begin : stimulus
    logic [spt_pkg::EXP_IO_W-1:0] fill_exp[15];
    logic [spt_pkg::FUNC_W-1:0]   f;
    logic [spt_pkg::EXP_IO_W-1:0] e;
    logic [spt_pkg::COEF_W-1:0]   c;
    logic [spt_pkg::COEF_W-1:0]   fill_coef;
    fill_exp = '{8'd200, 8'd100, 8'd150, 8'd50, 8'd250, 8'd10, 8'd120, 8'd180,
                 8'd90, 8'd30, 8'd60, 8'd240, 8'd5, 8'd140, 8'd70};
    fail_count      = 0;
    cycle_count     = 0;
    poly_terms      = 0;
    quiet_phase     = 1'b0;
    long_hold_req   = 1'b0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = spt_pkg::FUNC_ADD;
    in_ch.term_exp  = '0;
    in_ch.term_coef = '0;

    // query on empty table, saturation both ways, zero coef, cancel, unused func
    add_row(spt_pkg::FUNC_QUERY, 8'd0, 32'h1234_5678, 1'b1,
            make_result(8'd0, 0, '0, 1'b0));
    add_row(spt_pkg::FUNC_ADD, 8'd255, 32'h7fff_ffff, 1'b1,
            make_result(8'd255, 1, '0, 1'b0));
    add_row(spt_pkg::FUNC_ADD, 8'd255, 32'h0000_0001, 1'b1,
            make_result(8'd255, 1, '0, 1'b0));
    add_row(spt_pkg::FUNC_ADD, 8'd0, 32'h8000_0000, 1'b0, '0);
    add_row(spt_pkg::FUNC_ADD, 8'd0, 32'hffff_ffff, 1'b0, '0);
    add_row(spt_pkg::FUNC_ADD, 8'd7, 32'h0000_0000, 1'b0, '0);
    add_row(spt_pkg::FUNC_QUERY, 8'd255, 32'h0, 1'b1,
            make_result(8'd255, 2, 32'h7fff_ffff, 1'b0));
    add_row(spt_pkg::FUNC_ADD, 8'd255, 32'h8000_0001, 1'b1,
            make_result(8'd0, 1, '0, 1'b0));
    add_row(FUNC_UNUSED, 8'd0, 32'hffff_ffff, 1'b1, make_result(8'd0, 1, '0, 1'b0));
    // fill the table with inserts at the head, middle and tail
    for (int k = 0; k < 15; k++) begin
      fill_coef = 32'(k + 1) << 16;
      if (k % 2 == 1) fill_coef = -fill_coef;
      add_row(spt_pkg::FUNC_ADD, fill_exp[k], fill_coef, 1'b0, '0);
    end
    // full table: new exponent dropped, merge still allowed, then clear
    add_row(spt_pkg::FUNC_ADD, 8'd254, 32'h0000_0001, 1'b1,
            make_result(8'd250, 16, '0, 1'b1));
    add_row(spt_pkg::FUNC_ADD, 8'd100, 32'h0000_8000, 1'b0, '0);
    add_row(spt_pkg::FUNC_CLEAR, 8'd250, 32'h0000_0001, 1'b1,
            make_result(8'd0, 0, '0, 1'b0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].func, directed_rows[i].term_exp, directed_rows[i].term_coef,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // receiver backs up for a while so the block stalls its input
      if (n == 300) long_hold_req = 1'b1;
      // sender pauses until the result side has caught up
      if (n == 600) begin
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk_i);
      end
      quiet_phase = (n >= 700 && n < 800);
      pick_random_item(f, e, c);
      drive_item(f, e, c, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
    quiet_phase = 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sparse_polynomial_term_table test passed");
    end else begin
      $display("sparse_polynomial_term_table test failed");
    end
    $finish;
  end

endmodule
